// ===== sv/tcw_pkg.sv =====
`timescale 1ns / 1ps
package tcw_pkg;

   localparam int COLUMNS_DEF = 80;
   localparam int ROWS_DEF    = 25;

   localparam logic [2:0] KIND_PUT     = 3'd0;
   localparam logic [2:0] KIND_CLEAR   = 3'd1;
   localparam logic [2:0] KIND_SET     = 3'd2;
   localparam logic [2:0] KIND_REPAINT = 3'd3;
   localparam logic [2:0] KIND_READ    = 3'd4;

   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;

   localparam logic [1:0] CSR_FOREGROUND = 2'd0;
   localparam logic [1:0] CSR_BACKGROUND = 2'd1;
   localparam logic [1:0] CSR_CURSOR     = 2'd2;

   localparam logic [3:0] FG_RESET = 4'd2;
   localparam logic [3:0] BG_RESET = 4'd0;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_CHAR,
      OP_NEWLINE,
      OP_BACKSPACE,
      OP_CLEAR,
      OP_SET,
      OP_REPAINT,
      OP_READ
   } op_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_SCROLL_RD,
      ST_SCROLL_WR,
      ST_FILL,
      ST_CLEAR,
      ST_REP_RD,
      ST_REP_WR,
      ST_READ,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]        kind;
      logic [7:0]        char_code;
      logic signed [7:0] col_request;
      logic signed [7:0] row_request;
      logic [10:0]       cell_index;
   } req_type;

   typedef struct packed {
      logic [4:0]  cursor_row;
      logic [6:0]  cursor_col;
      logic [10:0] cursor_linear;
      logic [15:0] cell_value;
      logic        cursor_enabled;
   } rsp_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  ch;
      logic [7:0]  col;
      logic [7:0]  row;
      logic [10:0] idx;
      logic        idx_ok;
   } cmd_type;

endpackage

// ===== sv/tcw_front.sv =====
`timescale 1ns / 1ps
module tcw_front import tcw_pkg::*; #(
   parameter int COLUMNS = COLUMNS_DEF,
   parameter int ROWS    = ROWS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   input  logic    hold,
   output logic    cmd_valid,
   output cmd_type cmd,
   input  logic    cmd_take
);

   localparam int CELLS = COLUMNS * ROWS;

   cmd_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   cmd_type    cls;
   logic       push_ok;

   // classify the request
   always_comb begin
      cls        = '0;
      cls.op     = OP_NOP;
      cls.ch     = req_data.char_code;
      cls.idx    = req_data.cell_index;
      cls.idx_ok = {6'd0, req_data.cell_index} < 17'(CELLS);
      if (req_data.col_request < 0) begin
         cls.col = 8'd0;
      end else if ({1'b0, req_data.col_request} >= 9'(COLUMNS)) begin
         cls.col = 8'(COLUMNS - 1);
      end else begin
         cls.col = req_data.col_request;
      end
      if (req_data.row_request < 0) begin
         cls.row = 8'd0;
      end else if ({1'b0, req_data.row_request} >= 9'(ROWS)) begin
         cls.row = 8'(ROWS - 1);
      end else begin
         cls.row = req_data.row_request;
      end
      case (req_data.kind)
         KIND_PUT: begin
            if (req_data.char_code == CHAR_NEWLINE) begin
               cls.op = OP_NEWLINE;
            end else if (req_data.char_code == CHAR_BACKSPACE) begin
               cls.op = OP_BACKSPACE;
            end else begin
               cls.op = OP_CHAR;
            end
         end
         KIND_CLEAR:   cls.op = OP_CLEAR;
         KIND_SET:     cls.op = OP_SET;
         KIND_REPAINT: cls.op = OP_REPAINT;
         KIND_READ:    cls.op = OP_READ;
         default:      cls.op = OP_NOP;
      endcase
   end

   assign req_full  = (cnt_ff == 2'd2) || hold;
   assign push_ok   = req_push && !req_full;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push_ok;
      rd_ptr_in = rd_ptr_ff ^ cmd_take;
      cnt_in    = cnt_ff + {1'b0, push_ok} - {1'b0, cmd_take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

// ===== sv/tcw_engine.sv =====
`timescale 1ns / 1ps
module tcw_engine import tcw_pkg::*; #(
   parameter int COLUMNS = COLUMNS_DEF,
   parameter int ROWS    = ROWS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       cmd_valid,
   input  cmd_type    cmd,
   output logic       cmd_take,
   output logic       hold,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [3:0] csr_data,
   input  logic       rsp_pop,
   output logic       rsp_empty,
   output rsp_type    rsp_data
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int RW    = $clog2(ROWS);
   localparam int CW    = $clog2(COLUMNS);
   localparam logic [AW-1:0] LAST      = AW'(CELLS - 1);
   localparam logic [AW-1:0] MOVE_LAST = AW'(CELLS - COLUMNS - 1);
   localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
   localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);

   logic [15:0] mem [CELLS];

   state_type     state_ff, state_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [3:0]    fg_ff, fg_in;
   logic [3:0]    bg_ff, bg_in;
   logic          show_ff, show_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;
   logic [15:0]   rd_ff;
   logic [15:0]   cell_ff, cell_in;

   logic          go, need_scroll, we;
   logic [AW-1:0] wa, ra, lin;
   logic [15:0]   wd;
   logic [7:0]    attr;

   assign csr_ready = 1'b1;
   assign hold      = (state_ff == ST_INIT);
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign attr      = {bg_ff, fg_ff};
   assign lin       = AW'(row_ff * COLUMNS) + AW'(col_ff);
   assign go        = (state_ff == ST_IDLE) && cmd_valid && (!rsp_valid_ff || rsp_pop);
   assign need_scroll = (row_ff == ROW_LAST) &&
                        ((cmd.op == OP_NEWLINE) || ((cmd.op == OP_CHAR) && (col_ff == COL_LAST)));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT:      if (idx_ff == LAST) state_in = ST_IDLE;
         ST_IDLE: begin
            if (go) begin
               if (need_scroll) begin
                  state_in = ST_SCROLL_RD;
               end else if (cmd.op == OP_CLEAR) begin
                  state_in = ST_CLEAR;
               end else if (cmd.op == OP_REPAINT) begin
                  state_in = ST_REP_RD;
               end else if ((cmd.op == OP_READ) && cmd.idx_ok) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCROLL_RD: state_in = ST_SCROLL_WR;
         ST_SCROLL_WR: state_in = (idx_ff == MOVE_LAST) ? ST_FILL : ST_SCROLL_RD;
         ST_FILL:      if (idx_ff == LAST) state_in = ST_DONE;
         ST_CLEAR:     if (idx_ff == LAST) state_in = ST_DONE;
         ST_REP_RD:    state_in = ST_REP_WR;
         ST_REP_WR:    state_in = (idx_ff == LAST) ? ST_DONE : ST_REP_RD;
         ST_READ:      state_in = ST_DONE;
         ST_DONE:      state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cmd_take     = 1'b0;
      we           = 1'b0;
      wa           = idx_ff;
      wd           = {attr, CHAR_SPACE};
      ra           = idx_ff;
      idx_in       = idx_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      cell_in      = cell_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_in       = rsp_ff;
      fg_in        = fg_ff;
      bg_in        = bg_ff;
      show_in      = show_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_FOREGROUND: fg_in   = csr_data;
            CSR_BACKGROUND: bg_in   = csr_data;
            CSR_CURSOR:     show_in = csr_data[0];
            default:        ;
         endcase
      end
      case (state_ff)
         ST_INIT: begin
            we     = 1'b1;
            wd     = {BG_RESET, FG_RESET, CHAR_SPACE};
            idx_in = idx_ff + 1'b1;
         end
         ST_IDLE: begin
            if (go) begin
               cmd_take = 1'b1;
               cell_in  = 16'd0;
               idx_in   = '0;
               case (cmd.op)
                  OP_CHAR, OP_NEWLINE: begin
                     if (cmd.op == OP_CHAR) begin
                        we = 1'b1;
                        wa = lin;
                        wd = {attr, cmd.ch};
                     end
                     if ((cmd.op == OP_NEWLINE) || (col_ff == COL_LAST)) begin
                        col_in = '0;
                        if (row_ff != ROW_LAST) row_in = row_ff + 1'b1;
                     end else begin
                        col_in = col_ff + 1'b1;
                     end
                  end
                  OP_BACKSPACE: begin
                     if (col_ff != '0) begin
                        col_in = col_ff - 1'b1;
                        we     = 1'b1;
                        wa     = lin - 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     row_in = '0;
                     col_in = '0;
                  end
                  OP_SET: begin
                     col_in = CW'(cmd.col);
                     row_in = RW'(cmd.row);
                  end
                  OP_READ:  ra = AW'(cmd.idx);
                  default:  ;
               endcase
            end
         end
         ST_SCROLL_RD: ra = idx_ff + AW'(COLUMNS);
         ST_SCROLL_WR: begin
            we     = 1'b1;
            wd     = rd_ff;
            idx_in = idx_ff + 1'b1;
         end
         ST_FILL, ST_CLEAR: begin
            we     = 1'b1;
            idx_in = idx_ff + 1'b1;
         end
         ST_REP_WR: begin
            we     = 1'b1;
            wd     = {attr, rd_ff[7:0]};
            idx_in = idx_ff + 1'b1;
         end
         ST_READ: cell_in = rd_ff;
         ST_DONE: begin
            rsp_valid_in          = 1'b1;
            rsp_in.cursor_row     = 5'(row_ff);
            rsp_in.cursor_col     = 7'(col_ff);
            rsp_in.cursor_linear  = 11'(lin);
            rsp_in.cell_value     = cell_ff;
            rsp_in.cursor_enabled = show_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         idx_ff       <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         fg_ff        <= FG_RESET;
         bg_ff        <= BG_RESET;
         show_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         fg_ff        <= fg_in;
         bg_ff        <= bg_in;
         show_ff      <= show_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      cell_ff <= cell_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_ff <= mem[ra];
   end

   a_init_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INIT) |-> !rsp_valid_ff)
      else $error("result raised during store init");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (row_ff <= ROW_LAST) && (col_ff <= COL_LAST))
      else $error("cursor off screen");

   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> (state_ff == ST_IDLE) && cmd_valid)
      else $error("command taken while busy");

   a_done_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |=> rsp_valid_ff)
      else $error("finished command gave no result");

endmodule

// ===== sv/text_console_writer_top.sv =====
// Flow: put char, set cursor and unused kinds pass from acceptance through the done state
//   to the result; a valid read cell adds the read state before it; scroll reads and writes
//   each moved cell, then fills the last row; clear writes every cell; repaint reads and rewrites each cell.
// Requests: a new one starts only after the last is done and its result is popped.
// Reset: synchronous; cursor home, colors to defaults, then a pass fills every cell of the
//   store with blank cells, with full held high until it ends.
`timescale 1ns / 1ps
module text_console_writer_top import tcw_pkg::*; #(
   parameter int COLUMNS = COLUMNS_DEF,
   parameter int ROWS    = ROWS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  req_type    req_data,
   input  logic       rsp_pop,
   output logic       rsp_empty,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [3:0] csr_data
);

   logic    cmd_valid;
   logic    cmd_take;
   logic    hold;
   cmd_type cmd;

   tcw_front #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .hold      (hold),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take)
   );

   tcw_engine #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .hold      (hold),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
module tb;
   import tcw_pkg::*;

   localparam int COLS  = COLUMNS_DEF;
   localparam int ROWSN = ROWS_DEF;
   localparam int CELLS = COLS * ROWSN;
   localparam int IDLE_LIMIT = 20000;
   localparam int HOLD_CYCLES = 400;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   req_type    req_data = '0;
   logic       rsp_pop = 1'b0;
   logic       rsp_empty;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index = CSR_FOREGROUND;
   logic [3:0] csr_data = '0;

   text_console_writer_top DUT (.*);

   always #5 clock = ~clock;

   logic [15:0] screen_model [CELLS];
   int          row_now, col_now;
   logic [3:0]  fg_now, bg_now;
   logic        shown_now;
   rsp_type     pending_rsp [$];

   int errors = 0, n_req = 0, n_rsp = 0, n_scroll = 0, n_csr = 0;
   int tx_idle = 25, rx_idle = 88;
   int hold_trigger = 0;
   int idle_cycles = 0;

   function automatic logic [15:0] blank_cell(logic [7:0] ch);
      return {bg_now, fg_now, ch};
   endfunction

   function automatic int clamp_req(logic signed [7:0] v, int lim);
      if (v < 0) return 0;
      if (int'(v) >= lim) return lim - 1;
      return int'(v);
   endfunction

   function automatic void next_row();
      row_now++;
      if (row_now < ROWSN) return;
      n_scroll++;
      for (int i = 0; i < CELLS - COLS; i++) screen_model[i] = screen_model[i + COLS];
      for (int i = CELLS - COLS; i < CELLS; i++) screen_model[i] = blank_cell(CHAR_SPACE);
      row_now = ROWSN - 1;
   endfunction

   function automatic rsp_type console_predict(req_type r);
      rsp_type o;
      o.cell_value = '0;
      case (r.kind)
         KIND_PUT: begin
            if (r.char_code == CHAR_NEWLINE) begin
               col_now = 0;
               next_row();
            end else if (r.char_code == CHAR_BACKSPACE) begin
               if (col_now > 0) begin
                  col_now--;
                  screen_model[row_now * COLS + col_now] = blank_cell(CHAR_SPACE);
               end
            end else begin
               screen_model[row_now * COLS + col_now] = blank_cell(r.char_code);
               col_now++;
               if (col_now >= COLS) begin
                  col_now = 0;
                  next_row();
               end
            end
         end
         KIND_CLEAR: begin
            for (int i = 0; i < CELLS; i++) screen_model[i] = blank_cell(CHAR_SPACE);
            row_now = 0;
            col_now = 0;
         end
         KIND_SET: begin
            col_now = clamp_req(r.col_request, COLS);
            row_now = clamp_req(r.row_request, ROWSN);
         end
         KIND_REPAINT: begin
            for (int i = 0; i < CELLS; i++) screen_model[i] = blank_cell(screen_model[i][7:0]);
         end
         KIND_READ: begin
            if (r.cell_index < CELLS) o.cell_value = screen_model[r.cell_index];
         end
         default: ;
      endcase
      o.cursor_row     = row_now[4:0];
      o.cursor_col     = col_now[6:0];
      o.cursor_linear  = 11'(row_now * COLS + col_now);
      o.cursor_enabled = shown_now;
      return o;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0h want %0h (response %0d)", what, got, want, n_rsp);
      errors++;
   endtask

   // response checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         n_rsp++;
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected response", int'(rsp_data.cell_value), 0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.cursor_row != want.cursor_row)
               report_mismatch("cursor_row", int'(rsp_data.cursor_row),
                               int'(want.cursor_row));
            if (rsp_data.cursor_col != want.cursor_col)
               report_mismatch("cursor_col", int'(rsp_data.cursor_col),
                               int'(want.cursor_col));
            if (rsp_data.cursor_linear != want.cursor_linear)
               report_mismatch("cursor_linear", int'(rsp_data.cursor_linear),
                               int'(want.cursor_linear));
            if (rsp_data.cell_value != want.cell_value)
               report_mismatch("cell_value", int'(rsp_data.cell_value),
                               int'(want.cell_value));
            if (rsp_data.cursor_enabled != want.cursor_enabled)
               report_mismatch("cursor_enabled", int'(rsp_data.cursor_enabled),
                               int'(want.cursor_enabled));
         end
      end
   end

   // receiver; long hold-offs counted here
   always @(negedge clock) begin
      int seen, hold_left;
      if (hold_trigger != seen) begin
         seen = hold_trigger;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= rx_idle);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_req(req_type r, bit typed, rsp_type want, bit no_gap);
      rsp_type got;
      while (!no_gap && $urandom_range(99) < tx_idle) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_full);
      got = console_predict(r);
      pending_rsp.push_back(typed ? want : got);
      n_req++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_push <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [3:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_FOREGROUND: fg_now = val;
         CSR_BACKGROUND: bg_now = val;
         CSR_CURSOR:     shown_now = val[0];
         default: ;
      endcase
      n_csr++;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic req_type random_req();
      req_type r;
      logic [63:0] raw;
      int pick;
      raw = {$urandom, $urandom};
      r = raw[$bits(req_type)-1:0];
      pick = $urandom_range(99);
      if (pick < 70) begin
         r.kind = KIND_PUT;
         pick = $urandom_range(99);
         if (pick < 8) r.char_code = CHAR_NEWLINE;
         else if (pick < 14) r.char_code = CHAR_BACKSPACE;
      end else if (pick < 80) begin
         r.kind = KIND_SET;
         if ($urandom_range(1)) begin
            r.col_request = 8'($urandom_range(COLS - 1));
            r.row_request = 8'($urandom_range(ROWSN - 1));
         end
      end else if (pick < 94) begin
         r.kind = KIND_READ;
         if ($urandom_range(3) != 0) r.cell_index = 11'($urandom_range(CELLS - 1));
      end else if (pick < 95) begin
         r.kind = KIND_CLEAR;
      end else if (pick < 96) begin
         r.kind = KIND_REPAINT;
      end else begin
         r.kind = 3'($urandom_range(7, 5));
      end
      return r;
   endfunction

   typedef struct {
      logic [2:0]  kind;
      logic [7:0]  ch;
      logic [7:0]  col;
      logic [7:0]  row;
      logic [10:0] idx;
      bit          typed;
      rsp_type     want;
   } stim_row;

   stim_row stim_table [] = '{
      '{KIND_READ,    8'h00, 8'h00, 8'h00, 11'd0,    1, '{5'd0, 7'd0, 11'd0, 16'h0220, 1'b1}},
      '{KIND_READ,    8'h00, 8'h00, 8'h00, 11'd1999, 1, '{5'd0, 7'd0, 11'd0, 16'h0220, 1'b1}},
      '{KIND_READ,    8'h00, 8'h00, 8'h00, 11'd2047, 1, '{5'd0, 7'd0, 11'd0, 16'h0000, 1'b1}},
      '{KIND_PUT,     8'h41, 8'h00, 8'h00, 11'd0,    0, '0},
      '{KIND_PUT,     8'hFF, 8'hFF, 8'hFF, 11'h7FF,  0, '0},
      '{KIND_PUT,     8'h00, 8'h00, 8'h00, 11'd0,    0, '0},
      '{KIND_PUT,     CHAR_BACKSPACE, 8'h00, 8'h00, 11'd0, 0, '0},
      '{KIND_PUT,     CHAR_NEWLINE,   8'h00, 8'h00, 11'd0, 0, '0},
      '{KIND_SET,     8'h00, 8'h80, 8'h80, 11'd0,    1, '{5'd0, 7'd0, 11'd0, 16'h0000, 1'b1}},
      '{KIND_PUT,     CHAR_BACKSPACE, 8'h00, 8'h00, 11'd0, 0, '0},
      '{KIND_SET,     8'h00, 8'h7F, 8'h7F, 11'd0,    1, '{5'd24, 7'd79, 11'd1999, 16'h0, 1'b1}},
      '{KIND_PUT,     8'h5A, 8'h00, 8'h00, 11'd0,    0, '0},
      '{KIND_PUT,     CHAR_NEWLINE,   8'h00, 8'h00, 11'd0, 0, '0},
      '{KIND_SET,     8'h00, 8'd79, 8'd24, 11'd0,    0, '0},
      '{KIND_PUT,     8'h7E, 8'h00, 8'h00, 11'd0,    0, '0},
      '{KIND_READ,    8'h00, 8'h00, 8'h00, 11'd1919, 0, '0},
      '{KIND_REPAINT, 8'h00, 8'h00, 8'h00, 11'd0,    0, '0},
      '{KIND_READ,    8'h00, 8'h00, 8'h00, 11'd0,    0, '0},
      '{3'd5,         8'h00, 8'h00, 8'h00, 11'd0,    0, '0},
      '{3'd6,         8'h00, 8'h00, 8'h00, 11'd0,    0, '0},
      '{3'd7,         8'hFF, 8'hFF, 8'hFF, 11'h7FF,  0, '0},
      '{KIND_CLEAR,   8'h00, 8'h00, 8'h00, 11'd0,    0, '0},
      '{KIND_READ,    8'h00, 8'h00, 8'h00, 11'd5,    0, '0}
   };

   initial begin
      req_type r;
      for (int i = 0; i < CELLS; i++) screen_model[i] = 16'h0220;
      row_now = 0; col_now = 0;
      fg_now = FG_RESET; bg_now = BG_RESET; shown_now = 1'b1;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (stim_table[i]) begin
         r.kind = stim_table[i].kind;
         r.char_code = stim_table[i].ch;
         r.col_request = stim_table[i].col;
         r.row_request = stim_table[i].row;
         r.cell_index = stim_table[i].idx;
         send_req(r, stim_table[i].typed, stim_table[i].want, 0);
      end
      drain();

      for (int phase = 0; phase < 3; phase++) begin
         tx_idle = (phase == 0) ? 25 : (phase == 1) ? 88 : 0;
         rx_idle = (phase == 0) ? 88 : (phase == 1) ? 25 : 0;
         csr_write(CSR_FOREGROUND, (phase == 0) ? 4'hF : (phase == 1) ? 4'h0 : 4'($urandom));
         csr_write(CSR_BACKGROUND, (phase == 0) ? 4'h0 : (phase == 1) ? 4'hF : 4'($urandom));
         csr_write(CSR_CURSOR, (phase == 1) ? 4'd0 : 4'd1);
         for (int n = 0; n < 240; n++) begin
            send_req(random_req(), 0, '0, 0);
            if (n == 120) begin
               drain();
               csr_write(CSR_FOREGROUND, 4'($urandom));
               csr_write(CSR_BACKGROUND, 4'($urandom));
            end
         end
         drain();
      end

      // long receiver stall while requests keep coming
      hold_trigger++;
      for (int n = 0; n < 30; n++) begin
         r = random_req();
         r.kind = KIND_PUT;
         send_req(r, 0, '0, 1);
      end
      drain();

      $display("covered %0d requests, %0d responses, %0d scrolls, %0d register writes",
               n_req, n_rsp, n_scroll, n_csr);
      $display("three idle mixes plus a long response hold-off; %0d mismatches", errors);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/tcw_pkg.sv
sv/tcw_front.sv
sv/tcw_engine.sv
sv/text_console_writer_top.sv
verif/tb.sv
